FILE: hw/rtl/i2r_pkg.sv
// i2r_pkg: shared widths, microcode word layout, symbol codes and digit tables
// for the roman numeral encoder; no dependencies
`default_nettype none

package i2r_pkg;

  localparam int ValueW = 12;
  localparam int SymW   = 8;
  localparam int PcW    = 4;
  localparam int DigW   = 4;
  localparam int IdxW   = 2;
  localparam int LenW   = 3;
  localparam int PlaceW = 2;
  localparam int CmpW   = 14;

  localparam logic [ValueW-1:0] MaxValue = 12'd3999;

  // microcode step addresses
  localparam logic [PcW-1:0] PC_WAIT  = 4'd0;
  localparam logic [PcW-1:0] PC_CHECK = 4'd1;
  localparam logic [PcW-1:0] PC_DIG3  = 4'd2;
  localparam logic [PcW-1:0] PC_EMIT3 = 4'd3;
  localparam logic [PcW-1:0] PC_DIG2  = 4'd4;
  localparam logic [PcW-1:0] PC_EMIT2 = 4'd5;
  localparam logic [PcW-1:0] PC_DIG1  = 4'd6;
  localparam logic [PcW-1:0] PC_EMIT1 = 4'd7;
  localparam logic [PcW-1:0] PC_DIG0  = 4'd8;
  localparam logic [PcW-1:0] PC_EMIT0 = 4'd9;

  // decimal places
  localparam logic [PlaceW-1:0] PlaceOnes  = 2'd0;
  localparam logic [PlaceW-1:0] PlaceTens  = 2'd1;
  localparam logic [PlaceW-1:0] PlaceHuns  = 2'd2;
  localparam logic [PlaceW-1:0] PlaceThous = 2'd3;

  // symbol selectors within a place
  localparam logic [1:0] SelUnit = 2'd0;
  localparam logic [1:0] SelFive = 2'd1;
  localparam logic [1:0] SelTen  = 2'd2;

  localparam logic [SymW-1:0] SymNone = 8'h00;
  localparam logic [SymW-1:0] SymI    = 8'h49;
  localparam logic [SymW-1:0] SymV    = 8'h56;
  localparam logic [SymW-1:0] SymX    = 8'h58;
  localparam logic [SymW-1:0] SymL    = 8'h4C;
  localparam logic [SymW-1:0] SymC    = 8'h43;
  localparam logic [SymW-1:0] SymD    = 8'h44;
  localparam logic [SymW-1:0] SymM    = 8'h4D;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_CHECK,
    OP_DIGIT,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_START,
    C_BAD,
    C_ZERO_DIG,
    C_MORE_SYM,
    C_RUN_END
  } cond_t;

  // one microcode word
  typedef struct packed {
    op_t               op;
    logic [PlaceW-1:0] place;
    cond_t             hold;
    cond_t             jump;
    logic [PcW-1:0]    target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic start;
    logic bad;
    logic zero_dig;
    logic more_sym;
    logic run_end;
  } stat_t;

  function automatic logic [LenW-1:0] digit_len(input logic [DigW-1:0] d);
    logic [LenW-1:0] n;
    case (d)
      4'd1:    n = 3'd1;
      4'd2:    n = 3'd2;
      4'd3:    n = 3'd3;
      4'd4:    n = 3'd2;
      4'd5:    n = 3'd1;
      4'd6:    n = 3'd2;
      4'd7:    n = 3'd3;
      4'd8:    n = 3'd4;
      4'd9:    n = 3'd2;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] pat_sel(input logic [DigW-1:0] d,
                                         input logic [IdxW-1:0] i);
    logic [1:0] s;
    s = SelUnit;
    if (d == 4'd4) begin
      s = (i == '0) ? SelUnit : SelFive;
    end else if (d == 4'd9) begin
      s = (i == '0) ? SelUnit : SelTen;
    end else if (d inside {[4'd5:4'd8]}) begin
      s = (i == '0) ? SelFive : SelUnit;
    end
    return s;
  endfunction

  function automatic logic [SymW-1:0] place_sym(input logic [PlaceW-1:0] place,
                                                input logic [1:0] sel);
    logic [SymW-1:0] u;
    logic [SymW-1:0] f;
    logic [SymW-1:0] t;
    case (place)
      PlaceOnes: begin
        u = SymI; f = SymV; t = SymX;
      end
      PlaceTens: begin
        u = SymX; f = SymL; t = SymC;
      end
      PlaceHuns: begin
        u = SymC; f = SymD; t = SymM;
      end
      default: begin
        u = SymM; f = SymM; t = SymM;
      end
    endcase
    case (sel)
      SelFive: return f;
      SelTen:  return t;
      default: return u;
    endcase
  endfunction

  // k times the weight of a place, wide enough for nine thousand
  function automatic logic [CmpW-1:0] step_val(input logic [PlaceW-1:0] place,
                                               input logic [DigW-1:0] k);
    logic [CmpW-1:0] w;
    case (place)
      PlaceOnes:  w = 14'd1;
      PlaceTens:  w = 14'd10;
      PlaceHuns:  w = 14'd100;
      default:    w = 14'd1000;
    endcase
    return CmpW'(w * CmpW'(k));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2r_ucode.sv
// i2r_ucode: read-only microcode program of the roman numeral encoder
// depends on i2r_pkg
`default_nettype none

module i2r_ucode (
  input  logic [i2r_pkg::PcW-1:0] pc,
  output i2r_pkg::ctrl_t          ctrl
);
  import i2r_pkg::*;

  // one place = digit step (skip if zero) then emit step (hold per symbol)
  always_comb begin
    case (pc)
      PC_WAIT:  ctrl = '{op: OP_WAIT,  place: PlaceOnes,  hold: C_NO_START,
                         jump: C_NEVER,    target: PC_WAIT};
      PC_CHECK: ctrl = '{op: OP_CHECK, place: PlaceOnes,  hold: C_NEVER,
                         jump: C_BAD,      target: PC_WAIT};
      PC_DIG3:  ctrl = '{op: OP_DIGIT, place: PlaceThous, hold: C_NEVER,
                         jump: C_ZERO_DIG, target: PC_DIG2};
      PC_EMIT3: ctrl = '{op: OP_EMIT,  place: PlaceThous, hold: C_MORE_SYM,
                         jump: C_RUN_END,  target: PC_WAIT};
      PC_DIG2:  ctrl = '{op: OP_DIGIT, place: PlaceHuns,  hold: C_NEVER,
                         jump: C_ZERO_DIG, target: PC_DIG1};
      PC_EMIT2: ctrl = '{op: OP_EMIT,  place: PlaceHuns,  hold: C_MORE_SYM,
                         jump: C_RUN_END,  target: PC_WAIT};
      PC_DIG1:  ctrl = '{op: OP_DIGIT, place: PlaceTens,  hold: C_NEVER,
                         jump: C_ZERO_DIG, target: PC_DIG0};
      PC_EMIT1: ctrl = '{op: OP_EMIT,  place: PlaceTens,  hold: C_MORE_SYM,
                         jump: C_RUN_END,  target: PC_WAIT};
      PC_DIG0:  ctrl = '{op: OP_DIGIT, place: PlaceOnes,  hold: C_NEVER,
                         jump: C_ZERO_DIG, target: PC_WAIT};
      PC_EMIT0: ctrl = '{op: OP_EMIT,  place: PlaceOnes,  hold: C_MORE_SYM,
                         jump: C_ALWAYS,   target: PC_WAIT};
      default:  ctrl = '{op: OP_WAIT,  place: PlaceOnes,  hold: C_NEVER,
                         jump: C_ALWAYS,   target: PC_WAIT};
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_seq.sv
// i2r_seq: step counter with hold, jump and fall-through
// depends on i2r_pkg
`default_nettype none

module i2r_seq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  i2r_pkg::ctrl_t          ctrl,
  input  i2r_pkg::stat_t          stat,
  output logic [i2r_pkg::PcW-1:0] pc,
  output logic                    busy
);
  import i2r_pkg::*;

  logic [PcW-1:0] pc_r;
  logic [PcW-1:0] pc_nxt;
  logic           hold_hit;
  logic           jump_hit;

  function automatic logic cond_true(input cond_t c, input stat_t s);
    case (c)
      C_ALWAYS:   return 1'b1;
      C_NO_START: return !s.start;
      C_BAD:      return s.bad;
      C_ZERO_DIG: return s.zero_dig;
      C_MORE_SYM: return s.more_sym;
      C_RUN_END:  return s.run_end;
      default:    return 1'b0;
    endcase
  endfunction

  always_comb begin
    hold_hit = cond_true(ctrl.hold, stat);
    jump_hit = cond_true(ctrl.jump, stat);
    if (hold_hit) begin
      pc_nxt = pc_r;
    end else if (jump_hit) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + PcW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign pc   = pc_r;
  assign busy = (pc_r != PC_WAIT);

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_dp.sv
// i2r_dp: remainder, digit and symbol index registers plus output word register
// depends on i2r_pkg
`default_nettype none

module i2r_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  i2r_pkg::ctrl_t             ctrl,
  input  logic                       start,
  input  logic [i2r_pkg::ValueW-1:0] in_value,
  output i2r_pkg::stat_t             stat,
  output logic                       out_strobe,
  output logic [i2r_pkg::SymW-1:0]   out_symbol,
  output logic                       out_last,
  output logic                       out_of_range
);
  import i2r_pkg::*;

  logic [ValueW-1:0] rem_r,  rem_nxt;
  logic [DigW-1:0]   dig_r,  dig_nxt;
  logic [IdxW-1:0]   idx_r,  idx_nxt;
  logic              strobe_r, strobe_nxt;
  logic [SymW-1:0]   sym_r,  sym_nxt;
  logic              last_r, last_nxt;
  logic              oor_r,  oor_nxt;

  logic [DigW-1:0]   dig_calc;
  logic [CmpW-1:0]   sub_calc;
  logic              more_sym;
  logic              bad;

  // digit of the current place by parallel compares against k * weight
  always_comb begin
    dig_calc = '0;
    sub_calc = '0;
    for (int k = 1; k <= 9; k++) begin
      if (CmpW'(rem_r) >= step_val(ctrl.place, DigW'(k))) begin
        dig_calc = DigW'(k);
        sub_calc = step_val(ctrl.place, DigW'(k));
      end
    end
  end

  assign more_sym = ({1'b0, idx_r} != (digit_len(dig_r) - LenW'(1)));
  assign bad      = (rem_r > MaxValue) || (rem_r == '0);

  assign stat.start    = start;
  assign stat.bad      = bad;
  assign stat.zero_dig = (dig_calc == '0);
  assign stat.more_sym = more_sym;
  assign stat.run_end  = (rem_r == '0);

  always_comb begin
    rem_nxt    = rem_r;
    dig_nxt    = dig_r;
    idx_nxt    = idx_r;
    strobe_nxt = 1'b0;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    oor_nxt    = oor_r;
    case (ctrl.op)
      OP_WAIT: begin
        if (start) begin
          rem_nxt = in_value;
        end
      end
      OP_CHECK: begin
        if (rem_r > MaxValue) begin
          strobe_nxt = 1'b1;
          sym_nxt    = SymNone;
          last_nxt   = 1'b1;
          oor_nxt    = 1'b1;
        end
      end
      OP_DIGIT: begin
        dig_nxt = dig_calc;
        rem_nxt = rem_r - sub_calc[ValueW-1:0];
        idx_nxt = '0;
      end
      OP_EMIT: begin
        strobe_nxt = 1'b1;
        sym_nxt    = place_sym(ctrl.place, pat_sel(dig_r, idx_r));
        last_nxt   = !more_sym && (rem_r == '0);
        oor_nxt    = 1'b0;
        idx_nxt    = idx_r + IdxW'(1);
      end
      default: begin
        strobe_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= strobe_nxt;
    end
    rem_r  <= rem_nxt;
    dig_r  <= dig_nxt;
    idx_r  <= idx_nxt;
    sym_r  <= sym_nxt;
    last_r <= last_nxt;
    oor_r  <= oor_nxt;
  end

  assign out_strobe   = strobe_r;
  assign out_symbol   = sym_r;
  assign out_last     = last_r;
  assign out_of_range = oor_r;

endmodule

`default_nettype wire

FILE: hw/rtl/integer_to_roman_encoder_core.sv
// integer_to_roman_encoder_core: top level of the roman numeral encoder
// depends on i2r_pkg, i2r_ucode, i2r_seq, i2r_dp
//
//   channel   ports                                         handshake
//   input     in_value[11:0]                                start & !busy
//   result    out_symbol[7:0] out_last out_of_range         out_strobe, one cycle
//
// busy rises the cycle after a word is taken: one check step, then for each
// place a digit step and one emit step per symbol; the run stops after the
// last nonzero digit, or after the check step for zero or out-of-range input
// the microcode step counter paces the run and takes no new word until
// it is back at the wait step; each result shows the cycle after its step
// synchronous active-low reset returns the counter to the wait step
// results cannot be stalled: each word shows on the result ports for one cycle
`default_nettype none

module integer_to_roman_encoder_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [i2r_pkg::ValueW-1:0] in_value,
  output logic                       out_strobe,
  output logic [i2r_pkg::SymW-1:0]   out_symbol,
  output logic                       out_last,
  output logic                       out_of_range
);
  import i2r_pkg::*;

  logic [PcW-1:0] pc;
  ctrl_t          ctrl;
  stat_t          stat;

  // program store: one control word per step
  i2r_ucode u_ucode (
    .pc   (pc),
    .ctrl (ctrl)
  );

  // step counter, evaluates hold/jump conditions
  i2r_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat),
    .pc    (pc),
    .busy  (busy)
  );

  // remainder, digit extraction and symbol lookup
  i2r_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .start        (start),
    .in_value     (in_value),
    .stat         (stat),
    .out_strobe   (out_strobe),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .out_of_range (out_of_range)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_chk.sv
// i2r_chk: port-level checks on the roman numeral encoder, bound to the top level
// depends on i2r_pkg and integer_to_roman_encoder_core
`default_nettype none

module i2r_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [i2r_pkg::ValueW-1:0] in_value,
  input logic                       out_strobe,
  input logic [i2r_pkg::SymW-1:0]   out_symbol,
  input logic                       out_last,
  input logic                       out_of_range
);
  import i2r_pkg::*;

  // taking a word makes the block busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after word taken");

  // value above range gives the error word once the check step has run
  a_oor_word: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value > MaxValue)) |=> ##1 (out_strobe && out_of_range))
    else $error("missing out-of-range word");

  // zero gives no word once the check step has run
  a_zero_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_value == '0)) |=> ##1 !out_strobe)
    else $error("word emitted for zero");

  // error word is a lone, empty word
  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_of_range) |-> (out_last && (out_symbol == SymNone)))
    else $error("malformed out-of-range word");

  // normal words carry a numeral character
  a_sym_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_of_range) |->
      ((out_symbol == SymI) || (out_symbol == SymV) || (out_symbol == SymX) ||
       (out_symbol == SymL) || (out_symbol == SymC) || (out_symbol == SymD) ||
       (out_symbol == SymM)))
    else $error("symbol outside numeral set");

endmodule

bind integer_to_roman_encoder_core i2r_chk u_i2r_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_value     (in_value),
  .out_strobe   (out_strobe),
  .out_symbol   (out_symbol),
  .out_last     (out_last),
  .out_of_range (out_of_range)
);

`default_nettype wire
